@@ rtl/core/mixed_rational_normalizer_assert.svh @@
// Assertion macros for the normalizer RTL.
`ifndef MIXED_RATIONAL_NORMALIZER_ASSERT_SVH
`define MIXED_RATIONAL_NORMALIZER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define MRN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked on every clock edge outside reset.
`define MRN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/mrn_pkg.sv @@
package mrn_pkg;

    localparam int FRACTION_WIDTH_DEF = 63;
    localparam int WHOLE_W = 64;
    localparam int OUT_FRAC_W = 63;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the input transaction
        logic div_init; // start a restoring division num / den
        logic div_step; // one quotient bit
        logic carry;    // add quotient into whole, keep remainder
        logic gcd_init; // seed the gcd with denominator and numerator
        logic gcd_step; // one halving or subtract step of the binary gcd
        logic gdiv_init;// start dividing numerator by gcd
        logic gdiv_num_done; // store reduced numerator, start denominator
        logic gdiv_den_done; // store reduced denominator
        logic fac_init; // start factor stripping on the unreduced denominator
        logic fac_step; // strip one factor of 2 or step to the next power of 5
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic special;  // infinite or zero denominator
        logic improper; // numerator >= denominator
        logic div_last; // last quotient bit in progress
        logic num_zero; // numerator is zero after carry
        logic gcd_done; // gcd value is found
        logic gcd_gt1;  // gcd is larger than one
        logic fac_done; // factor stripping finished
    } t_status;

endpackage

@@ rtl/core/mrn_datapath.sv @@
module mrn_datapath #(
    parameter int FW = mrn_pkg::FRACTION_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mrn_pkg::t_cmd                  i_cmd,
    output mrn_pkg::t_status               o_status,
    input  logic                           i_negative_in,
    input  logic                           i_infinite_in,
    input  logic [mrn_pkg::WHOLE_W-1:0]    i_whole_in,
    input  logic [mrn_pkg::OUT_FRAC_W-1:0] i_numerator_in,
    input  logic [mrn_pkg::OUT_FRAC_W-1:0] i_denominator_in,
    input  logic                           i_decimal_known,
    output logic                           o_negative,
    output logic                           o_infinite,
    output logic [mrn_pkg::WHOLE_W-1:0]    o_whole,
    output logic [mrn_pkg::OUT_FRAC_W-1:0] o_numerator,
    output logic [mrn_pkg::OUT_FRAC_W-1:0] o_denominator,
    output logic                           o_is_integer,
    output logic                           o_is_decimal,
    output logic                           o_was_reduced,
    output logic                           o_zero_denominator,
    output logic                           o_whole_overflow
);
    import mrn_pkg::*;

    localparam int CW = $clog2(FW + 1);
    localparam int PW = FW + 3;

    logic [WHOLE_W-1:0] r_whole;
    logic [FW-1:0]      r_num, r_den, r_ga, r_gb, r_q, r_rem, r_dvd, r_dvs, r_fac;
    logic [PW-1:0]      r_pow;
    logic [CW-1:0]      r_cnt, r_gk;
    logic               r_neg, r_inf, r_dec, r_red, r_zd, r_ovf;

    logic [FW:0]        w_trial;
    logic [FW-1:0]      w_rshift;
    logic [WHOLE_W:0]   w_sum;
    logic [FW-1:0]      w_gcd;
    logic [PW-1:0]      w_fac_ext;
    logic [PW-1:0]      w_pow5;

    // Restoring division: shift the next dividend bit into the remainder.
    assign w_rshift = {r_rem[FW-2:0], r_dvd[FW-1]};
    assign w_trial  = {1'b0, w_rshift} - {1'b0, r_dvs};
    assign w_sum    = {1'b0, r_whole} + {{(WHOLE_W - FW + 1){1'b0}}, r_q};

    // The gcd is the odd part left by the binary gcd, times the common power of two.
    assign w_gcd = r_ga << r_gk;

    // Factor stripping: after the twos are shifted out, the odd part is compared
    // against successive powers of five, each one built as 4p + p.
    assign w_fac_ext = {3'b000, r_fac};
    assign w_pow5    = {r_pow[PW-3:0], 2'b00} + r_pow;

    assign o_status.special  = r_inf || (r_den == '0);
    assign o_status.improper = (r_num >= r_den);
    assign o_status.div_last = (r_cnt == CW'(1));
    assign o_status.num_zero = (r_num == '0);
    assign o_status.gcd_done = (r_gb == '0);
    assign o_status.gcd_gt1  = (r_ga > FW'(1)) || (r_gk != '0);
    assign o_status.fac_done = r_fac[0] && (w_fac_ext <= r_pow);

    // Datapath registers, all updated under controller commands.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            if (i_cmd.load) begin
                r_neg   <= i_negative_in;
                r_inf   <= i_infinite_in;
                r_whole <= i_infinite_in ? '0 : i_whole_in;
                r_num   <= i_numerator_in[FW-1:0];
                r_den   <= i_denominator_in[FW-1:0];
                r_dec   <= i_decimal_known;
                r_red   <= 1'b0;
                r_ovf   <= 1'b0;
                r_zd    <= !i_infinite_in && (i_denominator_in[FW-1:0] == '0);
                r_fac   <= FW'(1);
            end
            if (i_cmd.div_init || i_cmd.gdiv_init || i_cmd.gdiv_num_done) begin
                r_rem <= '0;
                r_q   <= '0;
                r_cnt <= CW'(FW);
                r_dvs <= i_cmd.div_init ? r_den : w_gcd;
                r_dvd <= (i_cmd.div_init || i_cmd.gdiv_init) ? r_num : r_den;
            end
            if (i_cmd.div_step) begin
                r_dvd <= {r_dvd[FW-2:0], 1'b0};
                r_cnt <= r_cnt - CW'(1);
                if (!w_trial[FW]) begin
                    r_rem <= w_trial[FW-1:0];
                    r_q   <= {r_q[FW-2:0], 1'b1};
                end else begin
                    r_rem <= w_rshift;
                    r_q   <= {r_q[FW-2:0], 1'b0};
                end
            end
            if (i_cmd.carry) begin
                r_num <= r_rem;
                r_red <= 1'b1;
                if (w_sum[WHOLE_W]) begin
                    r_whole <= '1;
                    r_ovf   <= 1'b1;
                end else begin
                    r_whole <= w_sum[WHOLE_W-1:0];
                end
            end
            if (i_cmd.gcd_init) begin
                r_ga <= r_den;
                r_gb <= r_num;
                r_gk <= '0;
            end
            if (i_cmd.gcd_step) begin
                // Binary gcd: halve even operands, subtract when both are odd.
                if (!r_ga[0] && !r_gb[0]) begin
                    r_ga <= {1'b0, r_ga[FW-1:1]};
                    r_gb <= {1'b0, r_gb[FW-1:1]};
                    r_gk <= r_gk + CW'(1);
                end else if (!r_ga[0]) begin
                    r_ga <= {1'b0, r_ga[FW-1:1]};
                end else if (!r_gb[0]) begin
                    r_gb <= {1'b0, r_gb[FW-1:1]};
                end else if (r_ga >= r_gb) begin
                    r_ga <= r_gb;
                    r_gb <= r_ga - r_gb;
                end else begin
                    r_gb <= r_gb - r_ga;
                end
            end
            if (i_cmd.gdiv_num_done) begin
                r_num <= r_q;
                r_red <= 1'b1;
            end
            if (i_cmd.gdiv_den_done) begin
                r_den <= r_q;
                r_fac <= r_q;
                r_pow <= PW'(1);
            end
            if (i_cmd.fac_init) begin
                r_fac <= r_den;
                r_pow <= PW'(1);
            end
            if (i_cmd.fac_step) begin
                if (!r_fac[0]) begin
                    r_fac <= {1'b0, r_fac[FW-1:1]};
                end else begin
                    r_pow <= w_pow5;
                end
            end
        end
    end

    // Result assembly from the final register contents.
    always_comb begin
        logic       fin_int;
        fin_int         = r_inf || r_zd || (r_num == '0);
        o_infinite      = r_inf;
        o_whole         = r_whole;
        o_numerator     = fin_int ? '0 : OUT_FRAC_W'(r_num);
        o_denominator   = fin_int ? OUT_FRAC_W'(1) : OUT_FRAC_W'(r_den);
        o_is_integer    = fin_int;
        o_is_decimal    = fin_int || r_dec || (w_fac_ext == r_pow);
        o_was_reduced   = r_red && !r_inf && !r_zd;
        o_zero_denominator = r_zd;
        o_whole_overflow = r_ovf && !r_inf && !r_zd;
        o_negative      = r_neg && (r_inf || (r_whole != '0) || !fin_int);
    end

endmodule

@@ rtl/core/mrn_ctrl.sv @@
module mrn_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    output mrn_pkg::t_cmd    o_cmd,
    input  mrn_pkg::t_status i_status
);
    import mrn_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_CARRY = 4'd3;
    localparam logic [3:0] S_GCDI  = 4'd4;
    localparam logic [3:0] S_GCD   = 4'd5;
    localparam logic [3:0] S_GDN   = 4'd6;
    localparam logic [3:0] S_GDD   = 4'd7;
    localparam logic [3:0] S_GDDE  = 4'd8;
    localparam logic [3:0] S_FAC   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_GDF   = 4'd11;

    logic [3:0] r_state, n_state;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    // Sequencer for load, special-case check, carry, gcd, factor stripping and output handshake.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.special) begin
                    n_state = S_OUT;
                end else if (i_status.improper) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end else begin
                    n_state = S_GCDI;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_CARRY;
                end
            end
            S_CARRY: begin
                o_cmd.carry = 1'b1;
                n_state     = S_GCDI;
            end
            S_GCDI: begin
                // Seed the gcd with the proper fraction, or finish if the numerator is zero.
                if (i_status.num_zero) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.gcd_init = 1'b1;
                    n_state        = S_GCD;
                end
            end
            S_GCD: begin
                if (i_status.gcd_done) begin
                    if (i_status.gcd_gt1) begin
                        o_cmd.gdiv_init = 1'b1;
                        n_state         = S_GDN;
                    end else begin
                        o_cmd.fac_init = 1'b1;
                        n_state        = S_FAC;
                    end
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_GDN: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_GDD;
                end
            end
            S_GDD: begin
                o_cmd.gdiv_num_done = 1'b1;
                n_state             = S_GDDE;
            end
            S_GDDE: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_GDF;
                end
            end
            S_GDF: begin
                // The quotient register holds the complete quotient once the last step is clocked.
                o_cmd.gdiv_den_done = 1'b1;
                n_state             = S_FAC;
            end
            S_FAC: begin
                if (i_status.fac_done) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.fac_step = 1'b1;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/core/mixed_rational_normalizer.sv @@
// Normalizes one signed mixed rational per transaction: carries the improper
// fraction into the whole part, reduces by the gcd and classifies the result.
// One transaction is in flight at a time. There are up to three bit-serial
// divisions (carry, numerator by gcd, denominator by gcd); the binary gcd
// halves or subtracts once per step, and factor stripping takes one step per
// factor of two plus one per power of five below the odd part. Special inputs
// go straight from the input check to the result.
module mixed_rational_normalizer #(
    parameter int FRACTION_WIDTH = mrn_pkg::FRACTION_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_negative_in,
    input  logic        i_infinite_in,
    input  logic [63:0] i_whole_in,
    input  logic [62:0] i_numerator_in,
    input  logic [62:0] i_denominator_in,
    input  logic        i_decimal_known,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_negative_out,
    output logic        o_infinite_out,
    output logic [63:0] o_whole_out,
    output logic [62:0] o_numerator_out,
    output logic [62:0] o_denominator_out,
    output logic        o_is_integer,
    output logic        o_is_decimal,
    output logic        o_was_reduced,
    output logic        o_zero_denominator,
    output logic        o_whole_overflow
);
    import mrn_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    mrn_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
        .o_cmd(w_cmd), .i_status(w_status)
    );

    mrn_datapath #(.FW(FRACTION_WIDTH)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_status(w_status),
        .i_negative_in, .i_infinite_in, .i_whole_in, .i_numerator_in,
        .i_denominator_in, .i_decimal_known,
        .o_negative(o_negative_out), .o_infinite(o_infinite_out),
        .o_whole(o_whole_out), .o_numerator(o_numerator_out),
        .o_denominator(o_denominator_out), .o_is_integer, .o_is_decimal,
        .o_was_reduced, .o_zero_denominator, .o_whole_overflow
    );

`include "mixed_rational_normalizer_assert.svh"

    // A result never shows a nonzero numerator together with an integer flag.
    `MRN_ASSERT_IMP(a_int_num, i_clk, i_rst_n, o_valid && o_is_integer, o_numerator_out == '0)
    // The denominator of a result is never zero.
    `MRN_ASSERT_IMP(a_den_nz, i_clk, i_rst_n, o_valid, o_denominator_out != '0)
    // A stalled result stays offered.
    `MRN_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)

endmodule

@@ bench/testbench.sv @@
module testbench;

    // One mixed rational as presented to the normalizer.
    typedef struct {
        logic        negative;
        logic        infinite;
        logic [63:0] whole;
        logic [62:0] numerator;
        logic [62:0] denominator;
        logic        decimal_known;
    } rational_t;

    // One normalized value with its classification flags.
    typedef struct packed {
        logic        negative;
        logic        infinite;
        logic [63:0] whole;
        logic [62:0] numerator;
        logic [62:0] denominator;
        logic        is_integer;
        logic        is_decimal;
        logic        was_reduced;
        logic        zero_denominator;
        logic        whole_overflow;
    } normalized_t;

    localparam int RANDOM_COUNT = 1880;
    localparam int HOLD_OFF_AT = 900;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;
    localparam int QUIET_FROM = 40000;
    localparam int QUIET_TO = 80000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_negative_in;
    logic        i_infinite_in;
    logic [63:0] i_whole_in;
    logic [62:0] i_numerator_in;
    logic [62:0] i_denominator_in;
    logic        i_decimal_known;
    logic        o_valid;
    logic        i_stall;
    logic        o_negative_out;
    logic        o_infinite_out;
    logic [63:0] o_whole_out;
    logic [62:0] o_numerator_out;
    logic [62:0] o_denominator_out;
    logic        o_is_integer;
    logic        o_is_decimal;
    logic        o_was_reduced;
    logic        o_zero_denominator;
    logic        o_whole_overflow;

    rational_t   pending_values[$];
    normalized_t expected_values[$];
    int          sent_count;
    int          checked_count;
    int          mismatch_count;
    int          cycle_count;
    int          quiet_count;
    bit          held_off;
    bit          hold_done;

    mixed_rational_normalizer i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_negative_in      (i_negative_in),
        .i_infinite_in      (i_infinite_in),
        .i_whole_in         (i_whole_in),
        .i_numerator_in     (i_numerator_in),
        .i_denominator_in   (i_denominator_in),
        .i_decimal_known    (i_decimal_known),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_negative_out     (o_negative_out),
        .o_infinite_out     (o_infinite_out),
        .o_whole_out        (o_whole_out),
        .o_numerator_out    (o_numerator_out),
        .o_denominator_out  (o_denominator_out),
        .o_is_integer       (o_is_integer),
        .o_is_decimal       (o_is_decimal),
        .o_was_reduced      (o_was_reduced),
        .o_zero_denominator (o_zero_denominator),
        .o_whole_overflow   (o_whole_overflow)
    );

    // Euclidean gcd on the fraction magnitudes.
    function automatic logic [63:0] gcd_of(logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    // True when the denominator has no prime factors besides 2 and 5.
    function automatic bit terminates_in_decimal(logic [63:0] d);
        if (d == 0) return 0;
        while (d % 2 == 0) d = d / 2;
        while (d % 5 == 0) d = d / 5;
        return d == 1;
    endfunction

    // Computes the normalized form of one value.
    function automatic normalized_t normalize(rational_t v);
        normalized_t r;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quotient;
        logic [63:0] g;
        r = '0;
        r.negative = v.negative;
        r.infinite = v.infinite;
        r.whole = v.whole;
        num = {1'b0, v.numerator};
        den = {1'b0, v.denominator};
        if (v.infinite) begin
            r.whole = 0;
            num = 0;
            den = 1;
        end else if (den == 0) begin
            r.zero_denominator = 1;
            num = 0;
            den = 1;
        end else begin
            if (num >= den) begin
                quotient = num / den;
                num = num % den;
                if (r.whole > ~quotient) begin
                    r.whole = '1;
                    r.whole_overflow = 1;
                end else begin
                    r.whole = r.whole + quotient;
                end
                r.was_reduced = 1;
            end
            if (num == 0) begin
                den = 1;
            end else begin
                g = gcd_of(num, den);
                if (g > 1) begin
                    num = num / g;
                    den = den / g;
                    r.was_reduced = 1;
                end
            end
        end
        if (!v.infinite && r.whole == 0 && num == 0) r.negative = 0;
        r.numerator = num[62:0];
        r.denominator = den[62:0];
        r.is_integer = (num == 0);
        r.is_decimal = r.is_integer || v.decimal_known || terminates_in_decimal(den);
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Fraction magnitude with a spread of sizes and factor structure.
    function automatic logic [62:0] rand_fraction();
        logic [63:0] x;
        int unsigned k;
        k = $urandom_range(0, 9);
        case (k)
            0: x = $urandom_range(0, 3);
            1, 2: x = $urandom_range(1, 1000);
            3: x = 64'd1 << $urandom_range(0, 62);
            4: x = (64'd1 << $urandom_range(0, 30)) * (64'd5 ** $urandom_range(0, 13));
            5: x = $urandom_range(1, 100000) * (64'd1 << $urandom_range(0, 20));
            6: x = rand64() >> $urandom_range(1, 62);
            default: x = rand64();
        endcase
        return x[62:0];
    endfunction

    function automatic rational_t make_value(logic n, logic inf, logic [63:0] w,
                                             logic [62:0] num, logic [62:0] den,
                                             logic dk);
        rational_t v;
        v.negative = n;
        v.infinite = inf;
        v.whole = w;
        v.numerator = num;
        v.denominator = den;
        v.decimal_known = dk;
        return v;
    endfunction

    // Random value; mostly finite with a valid denominator.
    function automatic rational_t rand_value();
        rational_t v;
        logic [62:0] common;
        v.negative = $urandom_range(0, 1);
        v.infinite = ($urandom_range(0, 19) == 0);
        case ($urandom_range(0, 3))
            0: v.whole = 0;
            1: v.whole = $urandom_range(0, 1000);
            2: v.whole = ~64'd0 - $urandom_range(0, 1000);
            default: v.whole = rand64();
        endcase
        v.numerator = rand_fraction();
        v.denominator = rand_fraction();
        if ($urandom_range(0, 3) == 0) begin
            // Shared factor so that gcd reduction has work to do.
            common = $urandom_range(2, 5000);
            v.numerator = (v.numerator % 63'd1000000) * common;
            v.denominator = ((v.denominator % 63'd1000000) + 63'd1) * common;
        end
        if ($urandom_range(0, 29) == 0) v.denominator = 0;
        v.decimal_known = ($urandom_range(0, 4) == 0);
        return v;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Stimulus: directed corner cases first, then random values.
    initial begin
        localparam logic [62:0] FMAX = '1;
        i_rst_n = 0;
        pending_values.push_back(make_value(0, 0, 0, 0, 1, 0));
        pending_values.push_back(make_value(1, 0, 0, 0, 1, 0));
        pending_values.push_back(make_value(0, 1, 5, 7, 3, 0));
        pending_values.push_back(make_value(1, 1, '1, FMAX, 0, 0));
        pending_values.push_back(make_value(1, 0, 0, 9, 0, 0));
        pending_values.push_back(make_value(1, 0, 42, 9, 0, 1));
        pending_values.push_back(make_value(0, 0, '1, FMAX, 1, 0));
        pending_values.push_back(make_value(1, 0, '1, 2, 1, 0));
        pending_values.push_back(make_value(0, 0, '1 - 3, 10, 3, 0));
        pending_values.push_back(make_value(1, 0, 0, 6, 6, 0));
        pending_values.push_back(make_value(1, 0, 0, 6, 4, 0));
        pending_values.push_back(make_value(0, 0, 3, 1, 3, 0));
        pending_values.push_back(make_value(0, 0, 3, 1, 3, 1));
        pending_values.push_back(make_value(0, 0, 0, 3, 8, 0));
        pending_values.push_back(make_value(0, 0, 0, 7, 250, 0));
        pending_values.push_back(make_value(0, 0, 0, 14, 60, 0));
        pending_values.push_back(make_value(0, 0, 0, FMAX - 1, FMAX, 0));
        pending_values.push_back(make_value(1, 0, '1, 1, FMAX, 1));
        pending_values.push_back(make_value(0, 0, 0, 63'd1 << 62, 63'd1 << 61, 0));
        pending_values.push_back(make_value(0, 0, 0, 1, 63'd1 << 62, 0));
        pending_values.push_back(make_value(1, 0, 1, 0, FMAX, 0));
        pending_values.push_back(make_value(0, 0, 0, 63'h5555_5555_5555_5555,
                                            63'h2aaa_aaaa_aaaa_aaaa, 0));
        for (int n = 0; n < RANDOM_COUNT; n++) pending_values.push_back(rand_value());
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        wait (pending_values.size() == 0 && !i_valid && expected_values.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Normalized %0d values: zero and infinite inputs, zero denominators,",
                 sent_count);
        $display("whole-part saturation, gcd reduction and decimal classification.");
        if (mismatch_count == 0 && expected_values.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Cycle count drives the quiet window with no idling on either side.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic bit take_idle();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 0;
        return $urandom_range(0, 99) < 10;
    endfunction

    // Driver: presents one transaction at a time and records its expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
            i_negative_in <= 0;
            i_infinite_in <= 0;
            i_whole_in <= 0;
            i_numerator_in <= 0;
            i_denominator_in <= 0;
            i_decimal_known <= 0;
            sent_count <= 0;
            held_off <= 0;
            hold_done <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_values.push_back(normalize(make_value(i_negative_in,
                    i_infinite_in, i_whole_in, i_numerator_in, i_denominator_in,
                    i_decimal_known)));
                sent_count <= sent_count + 1;
            end
            if (!i_valid || !o_stall) begin
                // Pause once mid-run until the block has drained completely.
                if (!hold_done && sent_count + (i_valid ? 1 : 0) >= HOLD_OFF_AT) begin
                    held_off <= 1;
                    hold_done <= 1;
                    i_valid <= 0;
                end else if (held_off && (expected_values.size() != 0 ||
                                          (i_valid && !o_stall))) begin
                    i_valid <= 0;
                end else if (pending_values.size() != 0 && !take_idle()) begin
                    held_off <= 0;
                    i_valid <= 1;
                    i_negative_in <= pending_values[0].negative;
                    i_infinite_in <= pending_values[0].infinite;
                    i_whole_in <= pending_values[0].whole;
                    i_numerator_in <= pending_values[0].numerator;
                    i_denominator_in <= pending_values[0].denominator;
                    i_decimal_known <= pending_values[0].decimal_known;
                    void'(pending_values.pop_front());
                end else begin
                    i_valid <= 0;
                end
            end
        end
    end

    // Monitor: checks each result transaction and drives random stalls.
    always @(posedge i_clk) begin
        normalized_t got;
        normalized_t want;
        if (!i_rst_n) begin
            i_stall <= 0;
            checked_count <= 0;
            mismatch_count <= 0;
        end else begin
            i_stall <= take_idle();
            if (o_valid && !i_stall) begin
                got = {o_negative_out, o_infinite_out, o_whole_out, o_numerator_out,
                       o_denominator_out, o_is_integer, o_is_decimal, o_was_reduced,
                       o_zero_denominator, o_whole_overflow};
                checked_count <= checked_count + 1;
                if (expected_values.size() == 0) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("Unexpected result %p", got);
                end else begin
                    want = expected_values.pop_front();
                    if (got !== want) begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < 10)
                            $display("Mismatch at result %0d:\n  expected %p\n  actual   %p",
                                     checked_count, want, got);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transaction.
    int stuck_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STALL_LIMIT) begin
                $display("Timeout with %0d results outstanding", expected_values.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

endmodule
